>>> sv/assert_macros.svh
// Assertion macros for the RTL file that checks its own logic.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition is true at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) \
    else $error("assertion failed: condition does not hold");

// Check that a condition in one cycle implies another one in the next cycle.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: expected follow-up missing");

// Check that a condition implies another one in the same cycle.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: implication violated");

`endif

>>> sv/lrupr_pkg.sv
// Shared constants and types of the LRU page replacement block.
`default_nettype none

package lrupr_pkg;

  localparam int FRAMES_DEF    = 4;
  localparam int PAGE_BITS_DEF = 10;
  localparam int COUNT_BITS    = 32;

  // Decision for one request, passed from the lookup to the frame store.
  typedef struct packed {
    logic hit;    // page resident, promote the frame
    logic evict;  // no empty frame, replace the least recent one
  } ctl_t;

endpackage

`default_nettype wire

>>> sv/lrupr_lookup.sv
// Frame lookup: hit compare, first empty frame and least recent victim.
`default_nettype none

module lrupr_lookup #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  wire logic [PAGE_BITS-1:0]       req_page,
  input  wire logic [FRAMES-1:0]          frame_valid,
  input  wire logic [PAGE_BITS-1:0]       frame_page [FRAMES],
  input  wire logic [$clog2(FRAMES)-1:0]  frame_rank [FRAMES],
  output lrupr_pkg::ctl_t                 ctl,
  output logic      [$clog2(FRAMES)-1:0]  slot,
  output logic      [PAGE_BITS-1:0]       victim_page
);

  localparam int SLOT_BITS = $clog2(FRAMES);
  localparam logic [SLOT_BITS-1:0] RANK_LAST = SLOT_BITS'(FRAMES - 1);

  logic                 hit_found;
  logic [SLOT_BITS-1:0] hit_idx;
  logic                 empty_found;
  logic [SLOT_BITS-1:0] empty_idx;
  logic [SLOT_BITS-1:0] victim_idx;
  logic [PAGE_BITS-1:0] victim_sel;

  // Scan from the top down so the lowest index wins each search.
  always_comb begin
    hit_found   = 1'b0;
    hit_idx     = '0;
    empty_found = 1'b0;
    empty_idx   = '0;
    victim_idx  = '0;
    victim_sel  = frame_page[0];
    for (int i = FRAMES - 1; i >= 0; i--) begin
      if (frame_valid[i] && (frame_page[i] == req_page)) begin
        hit_found = 1'b1;
        hit_idx   = SLOT_BITS'(i);
      end
      if (!frame_valid[i]) begin
        empty_found = 1'b1;
        empty_idx   = SLOT_BITS'(i);
      end
      if (frame_valid[i] && (frame_rank[i] == RANK_LAST)) begin
        victim_idx = SLOT_BITS'(i);
        victim_sel = frame_page[i];
      end
    end
  end

  always_comb begin
    ctl.hit     = hit_found;
    ctl.evict   = !hit_found && !empty_found;
    victim_page = victim_sel;
    priority if (hit_found) begin
      slot = hit_idx;
    end else if (empty_found) begin
      slot = empty_idx;
    end else begin
      slot = victim_idx;
    end
  end

endmodule

`default_nettype wire

>>> sv/lrupr_frames.sv
// Frame store: valid marks, page numbers and recency ranks with their update.
`default_nettype none

module lrupr_frames #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       upd,
  input  wire lrupr_pkg::ctl_t            ctl,
  input  wire logic [$clog2(FRAMES)-1:0]  slot,
  input  wire logic [PAGE_BITS-1:0]       req_page,
  output logic      [FRAMES-1:0]          frame_valid,
  output logic      [PAGE_BITS-1:0]       frame_page [FRAMES],
  output logic      [$clog2(FRAMES)-1:0]  frame_rank [FRAMES]
);

  localparam int SLOT_BITS = $clog2(FRAMES);

  logic [SLOT_BITS-1:0] hit_rank;

  assign hit_rank = frame_rank[slot];

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_valid <= '0;
      for (int i = 0; i < FRAMES; i++) begin
        frame_page[i] <= '0;
        frame_rank[i] <= '0;
      end
    end else if (upd) begin
      for (int i = 0; i < FRAMES; i++) begin
        if (SLOT_BITS'(i) == slot) begin
          // Promote or refill the chosen frame.
          frame_rank[i] <= '0;
          if (!ctl.hit) begin
            frame_valid[i] <= 1'b1;
            frame_page[i]  <= req_page;
          end
        end else if (frame_valid[i]) begin
          // Age the others; on a hit only those that were more recent.
          if (!ctl.hit || (frame_rank[i] < hit_rank)) begin
            frame_rank[i] <= frame_rank[i] + 1'b1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> sv/lru_page_replacement.sv
// Top level of the LRU page replacement block: request and result registers.
// Result: each accepted request sets req_valid, then raises done for one cycle.
// Throughput: one request per cycle while busy is low; the frame lookup and rank
//   update sit between the request register and the result register.
// Reset: synchronous rst empties all frames, clears the eviction count and holds
//   busy high until a clock edge with rst low. The receiver cannot stall.
`default_nettype none
`include "assert_macros.svh"

module lru_page_replacement #(
  parameter int FRAMES    = lrupr_pkg::FRAMES_DEF,
  parameter int PAGE_BITS = lrupr_pkg::PAGE_BITS_DEF
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             start,
  output logic                                  busy,
  input  wire logic [PAGE_BITS-1:0]             page,
  output logic                                  done,
  output logic                                  hit,
  output logic [$clog2(FRAMES)-1:0]             slot,
  output logic                                  evicted_valid,
  output logic [PAGE_BITS-1:0]                  evicted_page,
  output logic [lrupr_pkg::COUNT_BITS-1:0]      eviction_count
);

  localparam int SLOT_BITS = $clog2(FRAMES);
  localparam logic [lrupr_pkg::COUNT_BITS-1:0] COUNT_MAX = '1;

  // Request register: the page that the lookup works on this cycle.
  logic                 req_valid;
  logic [PAGE_BITS-1:0] req_page;

  // Frame state and the decision for the current request.
  logic [FRAMES-1:0]    frame_valid;
  logic [PAGE_BITS-1:0] frame_page [FRAMES];
  logic [SLOT_BITS-1:0] frame_rank [FRAMES];
  lrupr_pkg::ctl_t      ctl;
  logic [SLOT_BITS-1:0] sel_slot;
  logic [PAGE_BITS-1:0] victim_page;

  logic accept;

  assign accept = start && !busy;

  // Hold busy high through reset, drop it once the block is clean.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
    end else begin
      busy <= 1'b0;
    end
  end

  // Capture each accepted request; the page needs no reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      req_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      req_page <= page;
    end
  end

  lrupr_lookup #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_lookup (
    .req_page    (req_page),
    .frame_valid (frame_valid),
    .frame_page  (frame_page),
    .frame_rank  (frame_rank),
    .ctl         (ctl),
    .slot        (sel_slot),
    .victim_page (victim_page)
  );

  lrupr_frames #(
    .FRAMES    (FRAMES),
    .PAGE_BITS (PAGE_BITS)
  ) u_frames (
    .clk         (clk),
    .rst         (rst),
    .upd         (req_valid),
    .ctl         (ctl),
    .slot        (sel_slot),
    .req_page    (req_page),
    .frame_valid (frame_valid),
    .frame_page  (frame_page),
    .frame_rank  (frame_rank)
  );

  // Result strobe: one pulse per request, registered in the cycle after the lookup.
  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= req_valid;
    end
  end

  // Result payload; evicted_page reads zero when nothing was replaced.
  always_ff @(posedge clk) begin
    if (req_valid) begin
      hit           <= ctl.hit;
      slot          <= sel_slot;
      evicted_valid <= ctl.evict;
      evicted_page  <= ctl.evict ? victim_page : '0;
    end
  end

  // Eviction counter doubles as the result field; advance on each
  // replacement and saturate at all ones.
  always_ff @(posedge clk) begin
    if (rst) begin
      eviction_count <= '0;
    end else if (req_valid && ctl.evict && (eviction_count != COUNT_MAX)) begin
      eviction_count <= eviction_count + 1'b1;
    end
  end

  `ASSERT_NEXT(a_result_follows, clk, rst, req_valid, done)
  `ASSERT_IMPLIES(a_hit_no_evict, clk, rst, done, !(hit && evicted_valid))
  `ASSERT_IMPLIES(a_evict_counted, clk, rst, done && evicted_valid, eviction_count != '0)
  `ASSERT_IMPLIES(a_no_victim_page, clk, rst, done && !evicted_valid, evicted_page == '0)

endmodule

`default_nettype wire
